/* rtl/core/egd_pkg.sv */
// egd_pkg: shared types, constants and the per-bit decode step of the elias gamma decoder
// used by egd_front, egd_work_q, egd_back, egd_res_q and elias_gamma_decoder
// depends on nothing
`default_nettype none

package egd_pkg;

    // widest value the decoder builds; a longer prefix is reported as overflow
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int OUT_VALUE_W = 32;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = $clog2(BYTE_W);

    // queue between front and back
    localparam int WQ_DEPTH = 2;
    localparam int WQ_PTR_W = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERFLOW = 2'd2
    } egd_status_t;

    // what one bit does to the current code
    typedef enum logic [2:0] {
        EV_NONE,
        EV_ONE,
        EV_SUF_DONE,
        EV_SUF_TRUNC,
        EV_PFX_TRUNC,
        EV_ZERO_TRUNC,
        EV_OVERFLOW
    } egd_ev_t;

    typedef struct packed {
        logic [CNT_W-1:0] zero_count;
        logic             in_suffix;
        logic [CNT_W-1:0] bits_left;
    } egd_ctrl_t;

    localparam egd_ctrl_t CTRL_IDLE = '{zero_count: '0, in_suffix: 1'b0, bits_left: '0};

    typedef struct packed {
        egd_ctrl_t ctrl;
        egd_ev_t   ev;
    } egd_step_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } egd_in_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        egd_status_t            status;
        logic                   stream_done;
        logic                   last;
    } egd_out_t;

    // byte as classified by the front: which bit positions close a code
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic [BYTE_W-1:0] emit_mask;
    } egd_work_t;

    // control part of one decoded bit; the value path lives in the back
    function automatic egd_step_t egd_step(egd_ctrl_t c, logic b, logic endb);
        egd_step_t        r;
        logic [CNT_W-1:0] zc_inc;
        logic [CNT_W-1:0] left_dec;
        r        = '{ctrl: c, ev: EV_NONE};
        zc_inc   = CNT_W'(c.zero_count + 1'b1);
        left_dec = CNT_W'(c.bits_left - 1'b1);
        if (c.in_suffix) begin
            r.ctrl.bits_left = left_dec;
            if (left_dec == '0) begin
                r.ev   = EV_SUF_DONE;
                r.ctrl = CTRL_IDLE;
            end
            else if (endb) begin
                r.ev   = EV_SUF_TRUNC;
                r.ctrl = CTRL_IDLE;
            end
        end
        else if (b) begin
            if (c.zero_count == '0) begin
                r.ev   = EV_ONE;
                r.ctrl = CTRL_IDLE;
            end
            else if (endb) begin
                r.ev   = EV_PFX_TRUNC;
                r.ctrl = CTRL_IDLE;
            end
            else begin
                r.ctrl.in_suffix = 1'b1;
                r.ctrl.bits_left = c.zero_count;
            end
        end
        else begin
            r.ctrl.zero_count = zc_inc;
            if (zc_inc >= CNT_W'(VALUE_WIDTH)) begin
                r.ev   = EV_OVERFLOW;
                r.ctrl = CTRL_IDLE;
            end
            else if (endb) begin
                r.ev   = EV_ZERO_TRUNC;
                r.ctrl = CTRL_IDLE;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/elias_gamma_decoder.sv */
// elias_gamma_decoder: top level, byte stream in, decoded gamma values out
// depends on egd_pkg, egd_front, egd_work_q, egd_back, egd_res_q
`default_nettype none

// elias gamma decoder over a byte stream, bits taken msb first. an item is one
// byte plus a last_byte mark; each code (n zeros, a one, then n bits) yields one
// result word with the value, a status (complete, truncated at stream end,
// prefix overflow), stream_done on the final word of a stream and last on the
// final word caused by a byte. the bit engine in the back handles one bit per
// cycle as long as results drain, and a byte can produce up to 8 words, one
// per cycle. the front classifies each byte in the cycle it is taken and parks
// it in a 2-entry queue, so push is taken while the back still works on earlier
// bytes; a 4-entry result queue lets the engine run while results wait. the
// engine stalls only when a bit closes a code and the result queue is full.
module elias_gamma_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire egd_pkg::egd_in_t  item,
    output logic                   empty,
    input  wire logic              pop,
    output egd_pkg::egd_out_t      result
);
    import egd_pkg::*;

    // front to queue
    logic      wq_push;
    egd_work_t wq_entry;
    logic      wq_full;

    // queue to back
    egd_work_t wq_head;
    logic      wq_empty;
    logic      wq_pop;

    // back to result queue
    logic      rq_push;
    egd_out_t  rq_entry;
    logic      rq_full;

    // classify bytes on the way in
    egd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .wq_push  (wq_push),
        .wq_entry (wq_entry),
        .wq_full  (wq_full)
    );

    egd_work_q u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wq_push),
        .wr_data (wq_entry),
        .full    (wq_full),
        .rd_en   (wq_pop),
        .rd_data (wq_head),
        .empty   (wq_empty)
    );

    // one bit per cycle unless the result queue is full, builds the values
    egd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wq_head  (wq_head),
        .wq_empty (wq_empty),
        .wq_pop   (wq_pop),
        .rq_push  (rq_push),
        .rq_entry (rq_entry),
        .rq_full  (rq_full)
    );

    // oldest word sits on result while empty is low
    egd_res_q u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (rq_entry),
        .full    (rq_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

/* rtl/core/egd_front.sv */
// egd_front: accepts input bytes and marks the bit positions that close a code
// depends on egd_pkg
`default_nettype none

module egd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire egd_pkg::egd_in_t  item,
    output logic                   wq_push,
    output egd_pkg::egd_work_t     wq_entry,
    input  wire logic              wq_full
);
    import egd_pkg::*;

    egd_ctrl_t         ctrl_reg;
    egd_ctrl_t         ctrl_next;
    logic [BYTE_W-1:0] mask;

    // run the control path over the whole byte, msb first
    always_comb
    begin
        egd_ctrl_t c;
        egd_step_t s;
        c    = ctrl_reg;
        mask = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            s       = egd_step(c, item.data_byte[i], item.last_byte && (i == 0));
            mask[i] = (s.ev != EV_NONE);
            c       = s.ctrl;
        end
        ctrl_next = c;
    end

    assign full     = wq_full;
    assign wq_push  = push && !wq_full;
    assign wq_entry = '{data_byte: item.data_byte, last_byte: item.last_byte, emit_mask: mask};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_IDLE;
        end
        else if (wq_push)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/egd_work_q.sv */
// egd_work_q: short queue of classified bytes between front and back
// depends on egd_pkg
`default_nettype none

module egd_work_q (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire egd_pkg::egd_work_t wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output egd_pkg::egd_work_t      rd_data,
    output logic                    empty
);
    import egd_pkg::*;

    egd_work_t           mem_reg [WQ_DEPTH];
    logic [WQ_PTR_W-1:0] wr_ptr_reg;
    logic [WQ_PTR_W-1:0] rd_ptr_reg;
    logic [WQ_CNT_W-1:0] cnt_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (cnt_reg == WQ_CNT_W'(WQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [WQ_PTR_W-1:0] wq_inc(logic [WQ_PTR_W-1:0] p);
        return (p == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0 : WQ_PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wq_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= wq_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= WQ_CNT_W'(cnt_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= WQ_CNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_wq_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= WQ_CNT_W'(WQ_DEPTH))
        else $error("work queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/core/egd_res_q.sv */
// egd_res_q: result queue, the output side of the decoder
// depends on egd_pkg
`default_nettype none

module egd_res_q (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire egd_pkg::egd_out_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output egd_pkg::egd_out_t      rd_data,
    output logic                   empty
);
    import egd_pkg::*;

    egd_out_t            mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_CNT_W-1:0] cnt_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (cnt_reg == RQ_CNT_W'(RQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [RQ_PTR_W-1:0] rq_inc(logic [RQ_PTR_W-1:0] p);
        return (p == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : RQ_PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= rq_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rq_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= RQ_CNT_W'(cnt_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= RQ_CNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_rq_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/core/egd_back.sv */
// egd_back: bit engine, decodes one bit of the head byte per cycle while the result queue has room, and builds values
// depends on egd_pkg
`default_nettype none

module egd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire egd_pkg::egd_work_t wq_head,
    input  wire logic               wq_empty,
    output logic                    wq_pop,
    output logic                    rq_push,
    output egd_pkg::egd_out_t       rq_entry,
    input  wire logic               rq_full
);
    import egd_pkg::*;

    egd_ctrl_t              ctrl_reg;
    egd_ctrl_t              ctrl_next;
    logic [BIT_IDX_W-1:0]   idx_reg;
    logic [BIT_IDX_W-1:0]   idx_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;

    logic                   cur_bit;
    logic                   endb;
    egd_step_t              step;
    logic                   emit;
    logic                   advance;
    logic [VALUE_WIDTH-1:0] acc_shift;
    logic [CNT_W-1:0]       zc_inc;
    logic [CNT_W-1:0]       left_dec;
    logic [VALUE_WIDTH-1:0] val;
    egd_status_t            status;
    logic [BYTE_W-1:0]      below_mask;

    assign cur_bit   = wq_head.data_byte[idx_reg];
    assign endb      = wq_head.last_byte && (idx_reg == '0);
    assign step      = egd_step(ctrl_reg, cur_bit, endb);
    assign emit      = (step.ev != EV_NONE);
    assign advance   = !wq_empty && (!emit || !rq_full);
    assign acc_shift = {acc_reg[VALUE_WIDTH-2:0], cur_bit};
    assign zc_inc    = CNT_W'(ctrl_reg.zero_count + 1'b1);
    assign left_dec  = CNT_W'(ctrl_reg.bits_left - 1'b1);

    always_comb
    begin
        val    = '0;
        status = ST_OK;
        unique case (step.ev)
            EV_NONE:       val = '0;
            EV_ONE:        val = VALUE_WIDTH'(1);
            EV_SUF_DONE:   val = acc_shift;
            EV_SUF_TRUNC:
            begin
                val    = acc_shift << left_dec;
                status = ST_TRUNC;
            end
            EV_PFX_TRUNC:
            begin
                val    = VALUE_WIDTH'(1) << ctrl_reg.zero_count;
                status = ST_TRUNC;
            end
            EV_ZERO_TRUNC:
            begin
                val    = VALUE_WIDTH'(1) << zc_inc;
                status = ST_TRUNC;
            end
            EV_OVERFLOW:
            begin
                val    = '0;
                status = ST_OVERFLOW;
            end
            default:       val = '0;
        endcase
    end

    // last result of the byte when no lower bit position closes a code
    assign below_mask = BYTE_W'((BYTE_W'(1) << idx_reg) - 1'b1);

    assign rq_push  = advance && emit;
    assign rq_entry = '{value:       OUT_VALUE_W'(val),
                        status:      status,
                        stream_done: endb,
                        last:        !(|(wq_head.emit_mask & below_mask))};
    assign wq_pop   = advance && (idx_reg == '0);

    assign ctrl_next = advance ? step.ctrl : ctrl_reg;
    assign idx_next  = advance ? BIT_IDX_W'(idx_reg - 1'b1) : idx_reg;
    assign acc_next  = !advance ? acc_reg
                     : ctrl_reg.in_suffix ? acc_shift : VALUE_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_IDLE;
            idx_reg  <= BIT_IDX_W'(BYTE_W - 1);
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // front and back must agree on where codes close
    a_mask_agrees: assert property (@(posedge clk) disable iff (!rst_n)
        !wq_empty |-> (emit == wq_head.emit_mask[idx_reg]))
        else $error("back decode disagrees with front classification");

    a_stream_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (!wq_empty && endb) |-> emit)
        else $error("final bit of stream gave no result");

    a_stream_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && endb) |=> (ctrl_reg == CTRL_IDLE && idx_reg == BIT_IDX_W'(BYTE_W - 1)))
        else $error("decoder not restarted after stream end");

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for the elias gamma decoder, byte words in, decoded code words out
// depends on egd_pkg for the word types and status codes, and on elias_gamma_decoder as the unit
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import egd_pkg::*;

    // cycles allowed with no word moving on either side before the run is called hung
    localparam int STUCK_LIMIT   = 1000;
    // quiet time after the last expected word: long enough for two queued bytes plus margin
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    egd_in_t  item;
    logic     empty;
    logic     pop;
    egd_out_t result;

    elias_gamma_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // idle pressure, changed per phase by the test tasks
    int send_idle_pct;
    int pop_stall_pct;

    // scoreboard: decoded code words still owed by the unit, oldest first
    egd_out_t pending_codes[$];

    // bit-serial decoder state mirrored from the unit
    logic [5:0]  dec_zeros;
    logic        dec_in_suffix;
    logic [5:0]  dec_bits_left;
    logic [63:0] dec_acc;

    int bytes_sent;
    int streams_sent;
    int words_taken;
    int mismatches;
    int stuck_cycles;
    int done_seen;
    int status_seen [3];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // queue one decoded word and start over on a fresh code
    function automatic void add_code(logic [63:0] v, egd_status_t st, logic done);
        egd_out_t w;
        w.value       = v[OUT_VALUE_W-1:0];
        w.status      = st;
        w.stream_done = done;
        w.last        = 1'b0;
        pending_codes.push_back(w);
        dec_zeros     = '0;
        dec_in_suffix = 1'b0;
        dec_bits_left = '0;
        dec_acc       = '0;
    endfunction

    // walk one byte msb first and queue every code word it closes
    function automatic void decode_gamma_byte(egd_in_t in_w);
        int       first_new;
        logic     bit_v;
        logic     endb;
        egd_out_t w;
        first_new = pending_codes.size();
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            bit_v = in_w.data_byte[i];
            // only the lsb of a last_byte word can end the stream
            endb  = in_w.last_byte && (i == 0);
            if (dec_in_suffix) begin
                dec_acc       = {dec_acc[62:0], bit_v};
                dec_bits_left = dec_bits_left - 6'd1;
                if (dec_bits_left == 6'd0)
                    add_code(dec_acc, ST_OK, endb);
                else if (endb)
                    // cut inside the suffix: keep bits read, zero-fill the rest
                    add_code(dec_acc << dec_bits_left, ST_TRUNC, 1'b1);
            end
            else if (bit_v) begin
                if (dec_zeros == 6'd0)
                    add_code(64'd1, ST_OK, endb);
                else if (endb)
                    // stream ends right on the leading one of a longer code
                    add_code(64'd1 << dec_zeros, ST_TRUNC, 1'b1);
                else begin
                    dec_acc       = 64'd1;
                    dec_bits_left = dec_zeros;
                    dec_in_suffix = 1'b1;
                end
            end
            else begin
                dec_zeros = dec_zeros + 6'd1;
                if (dec_zeros >= VALUE_WIDTH || dec_zeros == 6'd0)
                    add_code(64'd0, ST_OVERFLOW, endb);
                else if (endb)
                    // stream ends on a prefix zero
                    add_code(64'd1 << dec_zeros, ST_TRUNC, 1'b1);
            end
        end
        // mark the final word this byte produced
        if (pending_codes.size() > first_new) begin
            w      = pending_codes.pop_back();
            w.last = 1'b1;
            pending_codes.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // called at a falling edge, returns at a falling edge with push still high,
    // so a back-to-back word never drops push within one time step
    task automatic send_byte(input logic [7:0] b, input logic lb);
        egd_in_t w;
        w.data_byte = b;
        w.last_byte = lb;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        // word moves at the first rising edge that sees full low
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_gamma_byte(w);
        bytes_sent++;
        if (lb)
            streams_sent++;
        @(negedge clk);
    endtask

    // hold the input off until every owed word has been taken
    task automatic wait_all_words();
        push <= 1'b0;
        @(negedge clk);
        while (pending_codes.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls on pop, checking on every taken word
    // ------------------------------------------------------------------

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    task automatic flag_word(input string what, input egd_out_t exp_w, input egd_out_t got_w);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"%0t %s: expected value %h status %0d done %b last %b,",
                      " got value %h status %0d done %b last %b"},
                     $realtime, what, exp_w.value, exp_w.status, exp_w.stream_done, exp_w.last,
                     got_w.value, got_w.status, got_w.stream_done, got_w.last);
    endtask

    always @(posedge clk) begin : take_words
        egd_out_t exp_w;
        if (rst_n && pop && !empty) begin
            words_taken++;
            if (pending_codes.size() == 0)
                flag_word("word with nothing owed", '0, result);
            else begin
                exp_w = pending_codes.pop_front();
                status_seen[int'(exp_w.status)]++;
                if (exp_w.stream_done)
                    done_seen++;
                if (result.value !== exp_w.value || result.status !== exp_w.status ||
                    result.stream_done !== exp_w.stream_done || result.last !== exp_w.last)
                    flag_word("word mismatch", exp_w, result);
            end
        end
    end

    // hang detector: counts cycles in which no word moves on either side
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d words still owed",
                     STUCK_LIMIT, pending_codes.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // n zeros, the leading one, then n low bits msb first
    task automatic append_code(inout bit code_bits[$], input int n, input logic [31:0] low);
        for (int k = 0; k < n; k++)
            code_bits.push_back(1'b0);
        code_bits.push_back(1'b1);
        for (int k = n - 1; k >= 0; k--)
            code_bits.push_back(low[k]);
    endtask

    // mostly short codes, a few long ones, the odd over-long prefix
    task automatic build_stream(inout bit code_bits[$]);
        int n_codes;
        int n;
        int pick;
        int cut;
        n_codes = $urandom_range(1, 8);
        for (int c = 0; c < n_codes; c++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                // prefix too long: overflow, leftover zeros start a new prefix
                n = $urandom_range(VALUE_WIDTH, VALUE_WIDTH + 6);
                for (int k = 0; k < n; k++)
                    code_bits.push_back(1'b0);
            end
            else begin
                if (pick < 60)
                    n = $urandom_range(0, 4);
                else if (pick < 90)
                    n = $urandom_range(5, 15);
                else
                    n = $urandom_range(16, VALUE_WIDTH - 1);
                append_code(code_bits, n, $urandom());
            end
        end
        // broken tail: drop a few bits so the stream ends mid code
        if ($urandom_range(9) < 3 && code_bits.size() > 1) begin
            cut = $urandom_range(1, (code_bits.size() - 1 < 10) ? code_bits.size() - 1 : 10);
            repeat (cut)
                void'(code_bits.pop_back());
        end
    endtask

    // one stream, possibly cut short, padded with random bits and closed by last_byte
    task automatic send_stream();
        bit         code_bits[$];
        logic [7:0] b;
        build_stream(code_bits);
        while (code_bits.size() > 0) begin
            for (int k = 7; k >= 0; k--)
                b[k] = (code_bits.size() > 0) ? code_bits.pop_front() : 1'($urandom_range(1));
            send_byte(b, code_bits.size() == 0);
        end
    endtask

    // ~80 percent streams, the rest raw bytes with random end marks
    task automatic run_streams(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 80)
                send_stream();
            else
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom()), $urandom_range(3) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_codes();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_byte(8'hFF, 1'b0);   // eight one-bit codes, most words one byte can give
        send_byte(8'hFF, 1'b1);   // stream ends on a complete lone one
        send_byte(8'h80, 1'b1);   // stream ends on a prefix zero
        send_byte(8'h01, 1'b1);   // stream ends on the leading one of a longer code
        send_byte(8'h05, 1'b1);   // stream ends inside the suffix
        send_byte(8'h40, 1'b1);   // short code then a truncated prefix
        send_byte(8'h00, 1'b1);   // all zeros, no word until the end mark
        // exactly 32 zeros: overflow in mid stream
        repeat (4)
            send_byte(8'h00, 1'b0);
        // overflow landing on the final bit of a stream
        repeat (3)
            send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // widest code: 31 zeros, a one, 31 ones gives all ones
        repeat (3)
            send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        repeat (3)
            send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_streams_free_flow();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        run_streams(80);
    endtask

    // also pauses once until the unit has handed over every owed word
    task automatic test_streams_sender_gaps();
        send_idle_pct = 63;
        pop_stall_pct = 0;
        run_streams(40);
        wait_all_words();
        run_streams(40);
    endtask

    task automatic test_streams_receiver_stall();
        send_idle_pct = 0;
        pop_stall_pct = 63;
        run_streams(80);
    endtask

    task automatic test_streams_both_idle();
        send_idle_pct = 37;
        pop_stall_pct = 37;
        run_streams(80);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        item          = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        bytes_sent    = 0;
        streams_sent  = 0;
        words_taken   = 0;
        mismatches    = 0;
        stuck_cycles  = 0;
        done_seen     = 0;
        for (int s = 0; s < 3; s++)
            status_seen[s] = 0;
        dec_zeros     = '0;
        dec_in_suffix = 1'b0;
        dec_bits_left = '0;
        dec_acc       = '0;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_codes();
        test_streams_free_flow();
        test_streams_sender_gaps();
        test_streams_receiver_stall();
        test_streams_both_idle();

        // drain, then give the unit time to show any stray word
        wait_all_words();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (pending_codes.size() != 0) begin
            $display("%0d expected words never arrived", pending_codes.size());
            mismatches++;
        end

        $display("sent %0d bytes in %0d streams, checked %0d words",
                 bytes_sent, streams_sent, words_taken);
        $display("%0d complete, %0d truncated, %0d overflow, %0d closed a stream, %0d failures",
                 status_seen[0], status_seen[1], status_seen[2], done_seen, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
